// File: src/gcps_pkg.sv
// Shared types, widths and constants of the central gravity particle step core.
// Used by gcps_isqrt, gcps_div and central_gravity_particle_step_core.
package gcps_pkg;

  // Fixed field widths
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned GRAV_W    = 48;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned CFG_DAT_W = 48;
  localparam int unsigned CFG_IDX_W = 3;

  // Square root unit: 66 bit radicand, one result bit per stage
  localparam int unsigned SQ_RAD_W  = 66;
  localparam int unsigned SQ_ROOT_W = 33;
  localparam int unsigned SQ_REM_W  = 34;

  // Divider unit: 64 bit dividend, 33 bit divisor, one quotient bit per stage
  localparam int unsigned DIV_W = 64;
  localparam int unsigned DVS_W = 33;

  // Pull magnitude width and limit
  localparam int unsigned PULL_W = 47;
  localparam logic [PULL_W-1:0] PULL_CAP = '1;

  // Pipeline valid positions: three front stages, root, clamp, two divides, five back stages
  localparam int unsigned V_S4 = 3 + SQ_ROOT_W;
  localparam int unsigned LAT  = 3 + SQ_ROOT_W + 1 + 2 * DIV_W + 5;

  // Register reset values
  localparam logic [WORD_W-1:0] RST_CENTER = '0;
  localparam logic [GRAV_W-1:0] RST_GRAV   = 48'h000F_4240_0000;
  localparam logic [STEP_W-1:0] RST_STEP   = 16'd3277;
  localparam logic [WORD_W-1:0] RST_BIAS   = 32'h000A_0000;
  localparam logic [WORD_W-1:0] RST_MIN_D  = 32'h0005_0000;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_GRAV     = 3'd2,
    CFG_STEP     = 3'd3,
    CFG_BIAS     = 3'd4,
    CFG_MIN_D    = 3'd5
  } cfg_idx_e;

  // Per-item data that rides alongside the arithmetic units
  typedef struct packed {
    logic [WORD_W-1:0] px;
    logic [WORD_W-1:0] py;
    logic [WORD_W-1:0] vx;
    logic [WORD_W-1:0] vy;
    logic [WORD_W-1:0] mass;
    logic [DVS_W-1:0]  adx;
    logic [DVS_W-1:0]  ady;
    logic              sx;
    logic              sy;
    logic [DVS_W-1:0]  d;
    logic [DVS_W-1:0]  dc;
    logic              tcap;
  } side_t;

  typedef struct packed {
    logic [WORD_W-1:0] val;
    logic              clip;
  } sat_t;

  localparam logic signed [48:0] S32_MAX_W = 49'sh0_0000_7FFF_FFFF;
  localparam logic signed [48:0] S32_MIN_W = 49'sh1_FFFF_8000_0000;

  // Clip a wide signed sum to the signed 32 bit range
  function automatic sat_t sat32(input logic signed [48:0] v);
    sat_t r;
    r.clip = 1'b1;
    if (v > S32_MAX_W) begin
      r.val = 32'h7FFF_FFFF;
    end else if (v < S32_MIN_W) begin
      r.val = 32'h8000_0000;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: src/gcps_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on gcps_pkg for widths.
module gcps_isqrt (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [gcps_pkg::SQ_RAD_W-1:0]    rad_i,
  output logic [gcps_pkg::SQ_ROOT_W-1:0]   root_o
);

  localparam int unsigned N = gcps_pkg::SQ_ROOT_W;

  logic [gcps_pkg::SQ_REM_W-1:0]  rem_q  [N-1];
  logic [gcps_pkg::SQ_RAD_W-1:0]  rad_q  [N-1];
  logic [gcps_pkg::SQ_ROOT_W-1:0] root_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [gcps_pkg::SQ_REM_W-1:0]  rem_in;
    logic [gcps_pkg::SQ_RAD_W-1:0]  rad_in;
    logic [gcps_pkg::SQ_ROOT_W-1:0] root_in;
    logic [gcps_pkg::SQ_REM_W+1:0]  rem_sh;
    logic [gcps_pkg::SQ_REM_W+1:0]  trial;
    logic [gcps_pkg::SQ_REM_W+1:0]  rem_nx;
    logic                           ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign root_in = root_q[i-1];
    end

    // Bring down the next pair and try root*4+1
    always_comb begin
      rem_sh = {rem_in, rad_in[gcps_pkg::SQ_RAD_W-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      ge     = (rem_sh >= trial);
      rem_nx = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[i] <= {root_in[gcps_pkg::SQ_ROOT_W-2:0], ge};
      end
    end

    if (i < N - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= rem_nx[gcps_pkg::SQ_REM_W-1:0];
          rad_q[i] <= {rad_in[gcps_pkg::SQ_RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

// File: src/gcps_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on gcps_pkg for widths. A zero divisor gives an all-ones quotient.
module gcps_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [gcps_pkg::DIV_W-1:0]    dvd_i,
  input  logic [gcps_pkg::DVS_W-1:0]    dvs_i,
  output logic [gcps_pkg::DIV_W-1:0]    quo_o
);

  localparam int unsigned N = gcps_pkg::DIV_W;

  logic [gcps_pkg::DVS_W-1:0] rem_q [N-1];
  logic [gcps_pkg::DVS_W-1:0] dvs_q [N-1];
  logic [gcps_pkg::DIV_W-1:0] dq_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [gcps_pkg::DVS_W-1:0] rem_in;
    logic [gcps_pkg::DVS_W-1:0] dvs_in;
    logic [gcps_pkg::DIV_W-1:0] dq_in;
    logic [gcps_pkg::DVS_W:0]   trial;
    logic [gcps_pkg::DVS_W:0]   rem_nx;
    logic                       ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dvs_in = dvs_i;
      assign dq_in  = dvd_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign dvs_in = dvs_q[i-1];
      assign dq_in  = dq_q[i-1];
    end

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
      trial  = {rem_in, dq_in[gcps_pkg::DIV_W-1]};
      ge     = (trial >= {1'b0, dvs_in});
      rem_nx = ge ? (trial - {1'b0, dvs_in}) : trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dq_q[i] <= {dq_in[gcps_pkg::DIV_W-2:0], ge};
      end
    end

    if (i < N - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= rem_nx[gcps_pkg::DVS_W-1:0];
          dvs_q[i] <= dvs_in;
        end
      end
    end
  end

  assign quo_o = dq_q[N-1];

endmodule

// File: src/central_gravity_particle_step_core.sv
// Central gravity particle step: semi-implicit Euler update in Q16.16.
// Depends on gcps_pkg, gcps_isqrt and gcps_div.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one particle per request:
//   position, velocity and mass. Output channel (out_valid_o/out_ready_i)
//   returns its next position and velocity with a saturation flag.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes one register per
//   request by index; it is always ready. Write it only while no particle
//   is in flight. Unknown indexes are dropped.
// Pipeline: from input request to result there are three front stages,
//   33 square root stages, one clamp stage, two 64 stage divides in series
//   (the pull term, then pull/bias/direction in parallel) and five stages
//   of scale, multiply and saturating add.
// Throughput: one particle per cycle unless stalled; all stages registered.
// Stall: the whole pipeline holds while the result waits and out_ready_i
//   is low; in_ready_o then drops. Nothing is lost or repeated.
// Reset: clears all valid bits and loads the register defaults.
module central_gravity_particle_step_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [31:0]                        pos_x_i,
  input  logic [31:0]                        pos_y_i,
  input  logic [31:0]                        vel_x_i,
  input  logic [31:0]                        vel_y_i,
  input  logic [31:0]                        particle_mass_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        next_pos_x_o,
  output logic [31:0]                        next_pos_y_o,
  output logic [31:0]                        next_vel_x_o,
  output logic [31:0]                        next_vel_y_o,
  output logic                               saturated_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gcps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gcps_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int unsigned LAT = gcps_pkg::LAT;
  localparam int unsigned SQN = gcps_pkg::SQ_ROOT_W;
  localparam int unsigned DVN = gcps_pkg::DIV_W;

  logic adv;

  // Configuration registers
  logic [31:0] center_x_q, center_y_q, bias_q, min_d_q;
  logic [47:0] grav_q;
  logic [15:0] step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= gcps_pkg::RST_CENTER;
      center_y_q <= gcps_pkg::RST_CENTER;
      grav_q     <= gcps_pkg::RST_GRAV;
      step_q     <= gcps_pkg::RST_STEP;
      bias_q     <= gcps_pkg::RST_BIAS;
      min_d_q    <= gcps_pkg::RST_MIN_D;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gcps_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i[31:0];
        gcps_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i[31:0];
        gcps_pkg::CFG_GRAV:     grav_q     <= cfg_data_i[47:0];
        gcps_pkg::CFG_STEP:     step_q     <= cfg_data_i[15:0];
        gcps_pkg::CFG_BIAS:     bias_q     <= cfg_data_i[31:0];
        gcps_pkg::CFG_MIN_D:    min_d_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Valid bits: advance together with the data
  logic [LAT-1:0] vld_q;

  assign adv         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Stage 1: offset to the center, magnitude and sign
  gcps_pkg::side_t s1_d, s1_q;
  logic [32:0] dx, dy;

  always_comb begin
    dx = {center_x_q[31], center_x_q} - {pos_x_i[31], pos_x_i};
    dy = {center_y_q[31], center_y_q} - {pos_y_i[31], pos_y_i};
    s1_d      = '0;
    s1_d.px   = pos_x_i;
    s1_d.py   = pos_y_i;
    s1_d.vx   = vel_x_i;
    s1_d.vy   = vel_y_i;
    s1_d.mass = particle_mass_i;
    s1_d.sx   = dx[32];
    s1_d.sy   = dy[32];
    s1_d.adx  = dx[32] ? (33'd0 - dx) : dx;
    s1_d.ady  = dy[32] ? (33'd0 - dy) : dy;
  end

  // Stage 2: squares; stage 3: sum
  gcps_pkg::side_t s2_q, s3_q;
  logic [65:0] sqx_q, sqy_q, rad_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= s1_d;
      sqx_q <= {33'd0, s1_q.adx} * {33'd0, s1_q.adx};
      sqy_q <= {33'd0, s1_q.ady} * {33'd0, s1_q.ady};
      s2_q  <= s1_q;
      rad_q <= sqx_q + sqy_q;
      s3_q  <= s2_q;
    end
  end

  // Distance through the root pipeline
  logic [32:0] root;
  gcps_pkg::side_t sqd_q [SQN];

  gcps_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqd_q[0] <= s3_q;
      for (int k = 1; k < SQN; k++) sqd_q[k] <= sqd_q[k-1];
    end
  end

  // Stage 4: clamp the distance from below
  gcps_pkg::side_t s4_d, s4_q;

  always_comb begin
    s4_d    = sqd_q[SQN-1];
    s4_d.d  = root;
    s4_d.dc = (root > {1'b0, min_d_q}) ? root : {1'b0, min_d_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv) s4_q <= s4_d;
  end

  // First divide: strength over clamped distance
  logic [63:0] t_quo;
  gcps_pkg::side_t td_q [DVN];

  gcps_div u_div_t (
    .clk_i (clk_i),
    .en_i  (adv),
    .dvd_i ({grav_q, 16'd0}),
    .dvs_i (s4_q.dc),
    .quo_o (t_quo)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      td_q[0] <= s4_q;
      for (int k = 1; k < DVN; k++) td_q[k] <= td_q[k-1];
    end
  end

  // Second divides: pull, bias over mass, unit direction
  gcps_pkg::side_t g_in;
  gcps_pkg::side_t gd_q [DVN];
  logic [63:0] g_quo, b_quo, ux_quo, uy_quo;

  always_comb begin
    g_in      = td_q[DVN-1];
    g_in.tcap = |t_quo[63:48];
  end

  gcps_div u_div_g (
    .clk_i (clk_i),
    .en_i  (adv),
    .dvd_i ({t_quo[47:0], 16'd0}),
    .dvs_i (g_in.dc),
    .quo_o (g_quo)
  );

  gcps_div u_div_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .dvd_i ({16'd0, bias_q, 16'd0}),
    .dvs_i ({1'b0, g_in.mass}),
    .quo_o (b_quo)
  );

  gcps_div u_div_ux (
    .clk_i (clk_i),
    .en_i  (adv),
    .dvd_i ({15'd0, g_in.adx, 16'd0}),
    .dvs_i (g_in.d),
    .quo_o (ux_quo)
  );

  gcps_div u_div_uy (
    .clk_i (clk_i),
    .en_i  (adv),
    .dvd_i ({15'd0, g_in.ady, 16'd0}),
    .dvs_i (g_in.d),
    .quo_o (uy_quo)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gd_q[0] <= g_in;
      for (int k = 1; k < DVN; k++) gd_q[k] <= gd_q[k-1];
    end
  end

  // Stage 5: limit pull and bias, add them
  logic [46:0] g_lim, b_lim, s5_d, s5_q;
  logic [47:0] s_sum;
  logic [16:0] ux5_q, uy5_q;
  gcps_pkg::side_t s5_side_q;

  always_comb begin
    g_lim = (gd_q[DVN-1].tcap || (|g_quo[63:47])) ? gcps_pkg::PULL_CAP : g_quo[46:0];
    b_lim = (|b_quo[63:47]) ? gcps_pkg::PULL_CAP : b_quo[46:0];
    s_sum = {1'b0, g_lim} + {1'b0, b_lim};
    s5_d  = s_sum[47] ? gcps_pkg::PULL_CAP : s_sum[46:0];
  end

  // Stage 6: scale by the time step; stage 7: project on each axis
  logic [62:0] a_prod;
  logic [46:0] a6_q;
  logic [16:0] ux6_q, uy6_q;
  gcps_pkg::side_t s6_side_q, s7_side_q;
  logic [63:0] mx_prod, my_prod;
  logic [46:0] mx7_q, my7_q;

  assign a_prod  = {16'd0, s5_q} * {47'd0, step_q};
  assign mx_prod = {17'd0, a6_q} * {47'd0, ux6_q};
  assign my_prod = {17'd0, a6_q} * {47'd0, uy6_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_q      <= s5_d;
      ux5_q     <= ux_quo[16:0];
      uy5_q     <= uy_quo[16:0];
      s5_side_q <= gd_q[DVN-1];
      a6_q      <= a_prod[62:16];
      ux6_q     <= ux5_q;
      uy6_q     <= uy5_q;
      s6_side_q <= s5_side_q;
      mx7_q     <= mx_prod[62:16];
      my7_q     <= my_prod[62:16];
      s7_side_q <= s6_side_q;
    end
  end

  // Stage 8: signed acceleration, new velocity
  logic [47:0] accx, accy;
  gcps_pkg::sat_t nvx_sat, nvy_sat;
  logic [31:0] nvx8_q, nvy8_q, px8_q, py8_q;
  logic        flag8_q;

  always_comb begin
    accx = '0;
    accy = '0;
    if (s7_side_q.d != '0) begin
      accx = s7_side_q.sx ? (48'd0 - {1'b0, mx7_q}) : {1'b0, mx7_q};
      accy = s7_side_q.sy ? (48'd0 - {1'b0, my7_q}) : {1'b0, my7_q};
    end
    nvx_sat = gcps_pkg::sat32({{17{s7_side_q.vx[31]}}, s7_side_q.vx} + {accx[47], accx});
    nvy_sat = gcps_pkg::sat32({{17{s7_side_q.vy[31]}}, s7_side_q.vy} + {accy[47], accy});
  end

  // Stage 9: new position into the output register
  gcps_pkg::sat_t npx_sat, npy_sat;
  logic [31:0] npx_q, npy_q, nvx_q, nvy_q;
  logic        sat_q;

  always_comb begin
    npx_sat = gcps_pkg::sat32({{17{px8_q[31]}}, px8_q} + {{17{nvx8_q[31]}}, nvx8_q});
    npy_sat = gcps_pkg::sat32({{17{py8_q[31]}}, py8_q} + {{17{nvy8_q[31]}}, nvy8_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nvx8_q  <= nvx_sat.val;
      nvy8_q  <= nvy_sat.val;
      px8_q   <= s7_side_q.px;
      py8_q   <= s7_side_q.py;
      flag8_q <= nvx_sat.clip | nvy_sat.clip;
      npx_q   <= npx_sat.val;
      npy_q   <= npy_sat.val;
      nvx_q   <= nvx8_q;
      nvy_q   <= nvy8_q;
      sat_q   <= flag8_q | npx_sat.clip | npy_sat.clip;
    end
  end

  assign next_pos_x_o = npx_q;
  assign next_pos_y_o = npy_q;
  assign next_vel_x_o = nvx_q;
  assign next_vel_y_o = nvy_q;
  assign saturated_o  = sat_q;

`ifndef SYNTH
  // Ready drops only when a result is waiting
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o) else $error("ready low without pending result");

  // A stall freezes every valid bit
  a_hold_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q)) else $error("valid bits moved during stall");

  // Clamped distance never below the root
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[gcps_pkg::V_S4] |-> (s4_q.dc >= s4_q.d)) else $error("clamp below distance");

  // A set flag means some result sits at a range limit
  a_sat_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (next_pos_x_o == 32'h7FFF_FFFF || next_pos_x_o == 32'h8000_0000 ||
       next_pos_y_o == 32'h7FFF_FFFF || next_pos_y_o == 32'h8000_0000 ||
       next_vel_x_o == 32'h7FFF_FFFF || next_vel_x_o == 32'h8000_0000 ||
       next_vel_y_o == 32'h7FFF_FFFF || next_vel_y_o == 32'h8000_0000))
    else $error("saturated flag without clipped value");
`endif

endmodule

// File: tb/central_gravity_particle_step_core_tb.sv
// Self-checking testbench of the central gravity particle step core.
// Depends on gcps_pkg and central_gravity_particle_step_core; drives random and directed
// particles under several register settings and checks every step against a local predictor.
`timescale 1ns / 100ps

module central_gravity_particle_step_core_tb;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] mass;
  } particle_t;

  typedef struct packed {
    logic [31:0] npx;
    logic [31:0] npy;
    logic [31:0] nvx;
    logic [31:0] nvy;
    logic        sat;
  } step_t;

  localparam logic [63:0] CAP64 = 64'h7FFF_FFFF_FFFF;

  // Register indexes with no register behind them
  localparam logic [gcps_pkg::CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [gcps_pkg::CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic [31:0] particle_mass_i = 32'd1;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] next_pos_x_o, next_pos_y_o, next_vel_x_o, next_vel_y_o;
  logic        saturated_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [gcps_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [gcps_pkg::CFG_DAT_W-1:0] cfg_data_i = '0;

  // Local copy of the register file
  logic [31:0] reg_cx, reg_cy, reg_bias, reg_min_d;
  logic [47:0] reg_grav;
  logic [15:0] reg_step;

  particle_t pending_particles[$];
  step_t     expected_steps[$];
  int        error_count = 0;
  int        steps_checked = 0;
  int        sat_seen = 0;
  int        phases_run = 0;
  bit        in_taken = 1'b0;
  bit        no_idle = 1'b0;
  int        in_gap = 0, out_gap = 0;

  central_gravity_particle_step_core DUT (.*);

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Floor square root of a 66 bit radicand
  function automatic logic [32:0] dist_root(input logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [33:0] r;
    rem = '0;
    r = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 68'(v[2*i +: 2]);
      r = r << 1;
      trial = (68'(r) << 1) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        r = r | 34'd1;
      end
    end
    return r[32:0];
  endfunction

  function automatic longint clip32(input longint v, inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Axis share of the acceleration, rounded toward zero
  function automatic longint axis_pull(input logic [63:0] a, input longint delta,
                                       input logic [63:0] d);
    logic [63:0] m, u;
    m = delta < 0 ? 64'(-delta) : 64'(delta);
    u = (m << 16) / d;
    m = (a * u) >> 16;
    return delta < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Expected next state of one particle
  function automatic step_t predict_step(input particle_t p);
    step_t r;
    longint dx, dy, accx, accy, nvx, nvy, npx, npy;
    logic [63:0] mx, my, d, dc, t, g, b, s, a;
    logic [65:0] rad;
    logic flag;
    dx = longint'($signed(reg_cx)) - longint'($signed(p.px));
    dy = longint'($signed(reg_cy)) - longint'($signed(p.py));
    mx = dx < 0 ? 64'(-dx) : 64'(dx);
    my = dy < 0 ? 64'(-dy) : 64'(dy);
    rad = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
    d = 64'(dist_root(rad));
    accx = 0;
    accy = 0;
    flag = 1'b0;
    if (d != 0) begin
      dc = d > 64'(reg_min_d) ? d : 64'(reg_min_d);
      t = (64'(reg_grav) << 16) / dc;
      if (t >= 64'h1_0000_0000_0000) g = CAP64;
      else begin
        g = (t << 16) / dc;
        if (g > CAP64) g = CAP64;
      end
      if (p.mass == 0) b = CAP64;
      else begin
        b = (64'(reg_bias) << 16) / 64'(p.mass);
        if (b > CAP64) b = CAP64;
      end
      s = g + b;
      if (s > CAP64) s = CAP64;
      a = (s * 64'(reg_step)) >> 16;
      accx = axis_pull(a, dx, d);
      accy = axis_pull(a, dy, d);
    end
    nvx = clip32(longint'($signed(p.vx)) + accx, flag);
    nvy = clip32(longint'($signed(p.vy)) + accy, flag);
    npx = clip32(longint'($signed(p.px)) + nvx, flag);
    npy = clip32(longint'($signed(p.py)) + nvy, flag);
    r.npx = npx[31:0];
    r.npy = npy[31:0];
    r.nvx = nvx[31:0];
    r.nvy = nvy[31:0];
    r.sat = flag;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sample both channels; predict on input request, check on output request
  always @(posedge clk_i) begin
    step_t want;
    in_taken = in_valid_i && in_ready_o;
    if (in_taken)
      expected_steps.insert(expected_steps.size(),
                            predict_step({pos_x_i, pos_y_i, vel_x_i, vel_y_i,
                                          particle_mass_i}));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("result with no request pending", next_pos_x_o, '0);
      end else begin
        want = expected_steps.pop_front();
        if (next_pos_x_o !== want.npx) report_mismatch("next_pos_x", next_pos_x_o, want.npx);
        if (next_pos_y_o !== want.npy) report_mismatch("next_pos_y", next_pos_y_o, want.npy);
        if (next_vel_x_o !== want.nvx) report_mismatch("next_vel_x", next_vel_x_o, want.nvx);
        if (next_vel_y_o !== want.nvy) report_mismatch("next_vel_y", next_vel_y_o, want.nvy);
        if (saturated_o !== want.sat)
          report_mismatch("saturated", 32'(saturated_o), 32'(want.sat));
        steps_checked++;
        if (want.sat) sat_seen++;
      end
    end
  end

  // Input driver: hold a request until taken, then advance after a random gap
  always @(negedge clk_i) begin
    particle_t p;
    logic nv;
    nv = in_valid_i;
    if (in_valid_i && in_taken) nv = 1'b0;
    if (rst_ni && !nv) begin
      if (in_gap > 0) in_gap--;
      else if (pending_particles.size() != 0) begin
        p = pending_particles.pop_front();
        pos_x_i <= p.px;
        pos_y_i <= p.py;
        vel_x_i <= p.vx;
        vel_y_i <= p.vy;
        particle_mass_i <= p.mass;
        nv = 1'b1;
        in_gap = pick_gap();
      end
    end
    in_valid_i <= nv;
  end

  // Output stall pattern
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      out_gap = pick_gap();
    end
  end

  task automatic write_reg(input logic [gcps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [47:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gcps_pkg::CFG_CENTER_X: reg_cx    = val[31:0];
      gcps_pkg::CFG_CENTER_Y: reg_cy    = val[31:0];
      gcps_pkg::CFG_GRAV:     reg_grav  = val;
      gcps_pkg::CFG_STEP:     reg_step  = val[15:0];
      gcps_pkg::CFG_BIAS:     reg_bias  = val[31:0];
      gcps_pkg::CFG_MIN_D:    reg_min_d = val[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_particle(input logic [31:0] px, py, vx, vy, mass);
    pending_particles.insert(pending_particles.size(), {px, py, vx, vy, mass});
  endtask

  // Random particle: mostly near the centre with modest speeds, some raw noise
  task automatic add_random(input int count);
    logic [31:0] px, py, vx, vy, m;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        px = $urandom; py = $urandom; vx = $urandom; vy = $urandom;
      end else begin
        px = reg_cx + 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        py = reg_cy + 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        vx = 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
        vy = 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      end
      m = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 32'h000F_FFFF);
      if (m == 0) m = 32'd1;
      add_particle(px, py, vx, vy, m);
    end
  endtask

  task automatic drain();
    while (pending_particles.size() != 0 || in_valid_i || expected_steps.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    phases_run++;
  endtask

  initial begin
    reg_cx = gcps_pkg::RST_CENTER;
    reg_cy = gcps_pkg::RST_CENTER;
    reg_grav = gcps_pkg::RST_GRAV;
    reg_step = gcps_pkg::RST_STEP;
    reg_bias = gcps_pkg::RST_BIAS;
    reg_min_d = gcps_pkg::RST_MIN_D;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers, special positions and extreme fields
    add_particle(32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
    add_particle(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    add_particle(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'd1);
    add_particle(32'h0, 32'hFFFE_0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
    add_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
    add_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
    add_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
    add_particle(32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    add_particle(32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'h0000_8000);
    add_particle(32'h0100_0000, 32'hFF00_0000, 32'h1234_5678, 32'hEDCB_A988, 32'h0002_0000);
    add_particle(32'h7FFF_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000);
    no_idle = 1'b1;
    add_random(40);
    drain();

    // Random settings, including writes to unknown indexes
    no_idle = 1'b0;
    write_reg(gcps_pkg::CFG_CENTER_X, 48'($urandom));
    write_reg(gcps_pkg::CFG_CENTER_Y, 48'($urandom));
    write_reg(gcps_pkg::CFG_GRAV, {16'($urandom), 32'($urandom)});
    write_reg(gcps_pkg::CFG_STEP, 48'($urandom));
    write_reg(gcps_pkg::CFG_BIAS, 48'($urandom));
    write_reg(gcps_pkg::CFG_MIN_D, 48'($urandom_range(0, 32'h00FF_FFFF)));
    write_reg(IDX_SPARE_A, 48'hFFFF_FFFF_FFFF);
    write_reg(IDX_SPARE_B, 48'h1234_5678_9ABC);
    add_particle(reg_cx, reg_cy, 32'h0, 32'h0, 32'd1);
    add_random(90);
    drain();

    // Largest values in every register but center Y, which is set most negative
    write_reg(gcps_pkg::CFG_CENTER_X, 48'h0000_7FFF_FFFF);
    write_reg(gcps_pkg::CFG_CENTER_Y, 48'h0000_8000_0000);
    write_reg(gcps_pkg::CFG_GRAV, 48'hFFFF_FFFF_FFFF);
    write_reg(gcps_pkg::CFG_STEP, 48'h0000_0000_FFFF);
    write_reg(gcps_pkg::CFG_BIAS, 48'h0000_FFFF_FFFF);
    write_reg(gcps_pkg::CFG_MIN_D, 48'h0000_FFFF_FFFF);
    add_particle(reg_cx, reg_cy, 32'h0, 32'h0, 32'd1);
    add_random(80);
    drain();

    // Smallest values in every register but center Y, which is set most positive
    write_reg(gcps_pkg::CFG_CENTER_X, 48'h0000_8000_0000);
    write_reg(gcps_pkg::CFG_CENTER_Y, 48'h0000_7FFF_FFFF);
    write_reg(gcps_pkg::CFG_GRAV, 48'h0);
    write_reg(gcps_pkg::CFG_STEP, 48'h0);
    write_reg(gcps_pkg::CFG_BIAS, 48'h0);
    write_reg(gcps_pkg::CFG_MIN_D, 48'h0);
    add_random(50);
    drain();
    write_reg(gcps_pkg::CFG_STEP, 48'h0000_0000_FFFF);
    write_reg(gcps_pkg::CFG_GRAV, 48'h0000_0100_0000);
    add_random(60);
    drain();

    // Strong pull with no distance floor
    write_reg(gcps_pkg::CFG_CENTER_X, 48'($urandom));
    write_reg(gcps_pkg::CFG_CENTER_Y, 48'($urandom));
    write_reg(gcps_pkg::CFG_GRAV, {16'($urandom), 32'($urandom)});
    write_reg(gcps_pkg::CFG_BIAS, 48'($urandom_range(0, 32'h00FF_FFFF)));
    add_random(90);
    drain();

    $display("Checked %0d particle steps over %0d register settings, %0d saturated.",
             steps_checked, phases_run, sat_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Timeout with %0d steps outstanding", expected_steps.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: central_gravity_particle_step_core.f
src/gcps_pkg.sv
src/gcps_isqrt.sv
src/gcps_div.sv
src/central_gravity_particle_step_core.sv
tb/central_gravity_particle_step_core_tb.sv
